>>> rtl/dmi_pkg.sv
// ----------------------------------------------------------------------------
// dmi_pkg
// Types, constants and state codes shared by the damped motion integrator.
// ----------------------------------------------------------------------------
package dmi_pkg;

   localparam int VelW = 24;
   localparam int PosW = 32;
   localparam int DtW  = 16;

   localparam logic signed [VelW-1:0] VelSnap = 24'sd6554;
   localparam logic signed [VelW-1:0] VelMax  = 24'sh7FFFFF;
   localparam logic signed [VelW-1:0] VelMin  = -24'sh800000;

   // register indexes
   localparam logic CsrDampRate = 1'b0;
   localparam logic CsrDampOff  = 1'b1;

   // heading codes
   localparam logic [1:0] HeadNorth = 2'd0;
   localparam logic [1:0] HeadSouth = 2'd1;
   localparam logic [1:0] HeadWest  = 2'd2;
   localparam logic [1:0] HeadEast  = 2'd3;

   typedef struct packed {
      logic signed [VelW-1:0] accel_x;
      logic signed [VelW-1:0] accel_y;
      logic [DtW-1:0]         time_step;
   } req_type;

   typedef struct packed {
      logic signed [PosW-1:0] new_pos_x;
      logic signed [PosW-1:0] new_pos_y;
      logic signed [VelW-1:0] new_vel_x;
      logic signed [VelW-1:0] new_vel_y;
      logic [1:0]             heading_out;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACCEL,
      ST_DAMP1,
      ST_DAMP2,
      ST_SQUARE,
      ST_SQRT,
      ST_DIV,
      ST_POS,
      ST_OUT
   } state_type;

   // which operand set the shared multiplier uses
   typedef enum logic [2:0] {
      MUL_ACCEL,
      MUL_DAMP1,
      MUL_DAMP2,
      MUL_SQUARE,
      MUL_POS
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        sqrt_start;
      logic        sqrt_step;
      logic        div_start;
      logic        div_step;
      logic        commit;
   } cmd_type;

   typedef struct packed {
      logic over_limit;
      logic sqrt_done;
      logic div_done;
   } sts_type;

   // saturate a wide sum into 24 bits
   function automatic logic signed [VelW-1:0] sat_vel(input logic signed [49:0] x);
      logic signed [VelW-1:0] r;
      if (x > 50'sd8388607)
         r = VelMax;
      else if (x < -50'sd8388608)
         r = VelMin;
      else
         r = x[VelW-1:0];
      return r;
   endfunction

endpackage

>>> rtl/dmi_ctrl.sv
// ----------------------------------------------------------------------------
// dmi_ctrl
// Sequencer: walks one transaction through acceleration, damping (skipped when off),
// speed limit (when over it) and position.
module dmi_ctrl import dmi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   input  logic      damp_off,
   input  sts_type   sts,
   output cmd_type   cmd
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_ACCEL;
         ST_ACCEL:  state_in = damp_off ? ST_SQUARE : ST_DAMP1;
         ST_DAMP1:  state_in = ST_DAMP2;
         ST_DAMP2:  state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_SQRT;
         ST_SQRT: begin
            if (!sts.over_limit) state_in = ST_POS;
            else if (sts.sqrt_done) state_in = ST_DIV;
         end
         ST_DIV:    if (sts.div_done) state_in = ST_POS;
         ST_POS:    state_in = ST_OUT;
         ST_OUT:    if (!rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      cmd.mul_sel = MUL_ACCEL;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_ACCEL:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_ACCEL; end
         ST_DAMP1:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DAMP1; end
         ST_DAMP2:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DAMP2; end
         ST_SQUARE: begin
            cmd.mul_en = 1'b1; cmd.mul_sel = MUL_SQUARE;
         end
         ST_SQRT: begin
            cmd.sqrt_step = sts.over_limit && !sts.sqrt_done;
            cmd.div_start = sts.over_limit && sts.sqrt_done;
         end
         ST_DIV:    cmd.div_step = !sts.div_done;
         ST_POS:    begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_POS; cmd.commit = 1'b1; end
         ST_OUT:    rsp_valid = 1'b1;
         default:   ;
      endcase
      cmd.sqrt_start = 1'b0;
      if (state_ff == ST_SQUARE) cmd.sqrt_start = 1'b1;
   end

   // advance
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

>>> rtl/dmi_datapath.sv
// ----------------------------------------------------------------------------
// dmi_datapath
// Kept body state, shared multiplier, bit-serial square root and divider.
// ----------------------------------------------------------------------------
module dmi_datapath import dmi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic [15:0] damp_rate,
   input  cmd_type     cmd,
   output sts_type     sts,
   output rsp_type     rsp_data
);

   logic signed [VelW-1:0] vel_x_ff, vel_y_ff, vel_x_in, vel_y_in;
   logic signed [PosW-1:0] pos_x_ff, pos_y_ff;
   logic [1:0]             head_ff;
   logic signed [VelW-1:0] ax_ff, ay_ff;
   logic [DtW-1:0]         dt_ff;
   logic signed [40:0]     dv_x_ff, dv_y_ff;   // damping r*v, Q.28
   logic [48:0]            sq_ff;              // speed squared Q.32
   logic                   over_ff;            // speed above the limit
   // square root
   logic [48:0]            rem_ff;
   logic [25:0]            root_ff;
   logic [4:0]             sq_cnt_ff;
   logic                   sqrt_done_ff;
   // divider, both components at once
   logic [41:0]            nx_ff, ny_ff;
   logic [23:0]            qx_ff, qy_ff;
   logic [5:0]             dv_cnt_ff;
   logic                   div_done_ff;

   // shared multiplier operands (two lanes, x and y)
   logic signed [40:0] opa_x, opa_y;
   logic signed [24:0] opb_x, opb_y;
   logic signed [65:0] prod_x, prod_y;
   logic signed [49:0] rnd_x, rnd_y;
   logic [48:0]        sq_sum;

   always_comb begin
      opa_x = 41'(ax_ff); opa_y = 41'(ay_ff);
      opb_x = 25'(signed'({1'b0, dt_ff})); opb_y = opb_x;
      case (cmd.mul_sel)
         MUL_ACCEL:  ;
         MUL_DAMP1: begin
            opa_x = 41'(vel_x_ff); opa_y = 41'(vel_y_ff);
            opb_x = 25'(signed'({1'b0, damp_rate})); opb_y = opb_x;
         end
         MUL_DAMP2: begin
            opa_x = dv_x_ff; opa_y = dv_y_ff;
         end
         MUL_SQUARE: begin
            opa_x = 41'(vel_x_ff); opa_y = 41'(vel_y_ff);
            opb_x = 25'(vel_x_ff); opb_y = 25'(vel_y_ff);
         end
         MUL_POS:    begin opa_x = 41'(vel_x_ff); opa_y = 41'(vel_y_ff); end
         default:    ;
      endcase
      prod_x = 66'(opa_x) * 66'(opb_x);
      prod_y = 66'(opa_y) * 66'(opb_y);
   end

   assign sq_sum = 49'(prod_x[47:0]) + 49'(prod_y[47:0]);

   // round half up: floor((p + half) >> k)
   function automatic logic signed [49:0] rshift(input logic signed [65:0] p,
                                                 input logic big);
      logic signed [65:0] t;
      if (big) begin
         t = p + 66'sd8388608;
         return 50'(t >>> 24);
      end
      t = p + 66'sd2048;
      return 50'(t >>> 12);
   endfunction

   assign rnd_x = rshift(prod_x, cmd.mul_sel == MUL_DAMP2);
   assign rnd_y = rshift(prod_y, cmd.mul_sel == MUL_DAMP2);

   // load: apply snap-to-zero when there is no acceleration
   logic no_acc;
   assign no_acc = (req_data.accel_x == '0) && (req_data.accel_y == '0);

   function automatic logic snap(input logic signed [VelW-1:0] v);
      return (v > -VelSnap) && (v < VelSnap);
   endfunction

   logic [26:0] wx, wy;   // partial remainders
   logic [26:0] px_ff, py_ff;
   logic [26:0] sx, sy;
   assign sx = {px_ff[25:0], nx_ff[41]} - {1'b0, root_ff};
   assign sy = {py_ff[25:0], ny_ff[41]} - {1'b0, root_ff};
   assign wx = sx[26] ? {px_ff[25:0], nx_ff[41]} : sx;
   assign wy = sy[26] ? {py_ff[25:0], ny_ff[41]} : sy;

   // square root trial, two bits a step
   logic [50:0] sr_rem;
   logic [27:0] sr_trial;
   logic [50:0] sr_sub;
   assign sr_rem   = {rem_ff, sq_ff[47:46]};
   assign sr_trial = {root_ff, 2'b01};
   assign sr_sub   = sr_rem - 51'(sr_trial);

   logic [23:0] ax_abs, ay_abs;
   assign ax_abs = vel_x_ff[23] ? 24'(-vel_x_ff) : 24'(vel_x_ff);
   assign ay_abs = vel_y_ff[23] ? 24'(-vel_y_ff) : 24'(vel_y_ff);

   assign sts.over_limit = over_ff;
   assign sts.sqrt_done  = sqrt_done_ff;
   assign sts.div_done   = div_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_x_ff <= '0; vel_y_ff <= '0;
         pos_x_ff <= '0; pos_y_ff <= '0;
         head_ff  <= HeadNorth;
         sqrt_done_ff <= 1'b0;
         div_done_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            ax_ff <= req_data.accel_x;
            ay_ff <= req_data.accel_y;
            dt_ff <= req_data.time_step;
            if (no_acc) begin
               if (snap(vel_x_ff)) vel_x_ff <= '0;
               if (snap(vel_y_ff)) vel_y_ff <= '0;
            end
         end
         if (cmd.mul_en) begin
            case (cmd.mul_sel)
               MUL_ACCEL: if (ax_ff != '0 || ay_ff != '0) begin
                  vel_x_ff <= sat_vel(50'(vel_x_ff) + rnd_x);
                  vel_y_ff <= sat_vel(50'(vel_y_ff) + rnd_y);
               end
               MUL_DAMP1: begin
                  dv_x_ff <= prod_x[40:0];
                  dv_y_ff <= prod_y[40:0];
               end
               MUL_DAMP2: begin
                  vel_x_ff <= sat_vel(50'(vel_x_ff) - rnd_x);
                  vel_y_ff <= sat_vel(50'(vel_y_ff) - rnd_y);
               end
               // keep the limit flag; the radicand shifts away during the root
               MUL_SQUARE: begin
                  sq_ff   <= sq_sum;
                  over_ff <= sq_sum > 49'(64'd16 << 32);
               end
               MUL_POS: begin : pos_upd
                  logic signed [49:0] sx2, sy2;
                  sx2 = 50'(pos_x_ff) + rnd_x;
                  sy2 = 50'(pos_y_ff) + rnd_y;
                  pos_x_ff <= (sx2 > 50'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                              (sx2 < -50'sh80000000) ? -32'sh80000000 : sx2[31:0];
                  pos_y_ff <= (sy2 > 50'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                              (sy2 < -50'sh80000000) ? -32'sh80000000 : sy2[31:0];
               end
               default: ;
            endcase
         end
         // sqrt: 24 steps of two bits over a 48-bit radicand
         if (cmd.sqrt_start) begin
            rem_ff <= '0; root_ff <= '0; sq_cnt_ff <= '0; sqrt_done_ff <= 1'b0;
         end else if (cmd.sqrt_step) begin
            sq_ff <= {sq_ff[46:0], 2'b00};
            if (!sr_sub[50]) begin
               rem_ff  <= sr_sub[48:0];
               root_ff <= {root_ff[24:0], 1'b1};
            end else begin
               rem_ff  <= sr_rem[48:0];
               root_ff <= {root_ff[24:0], 1'b0};
            end
            sq_cnt_ff    <= sq_cnt_ff + 5'd1;
            sqrt_done_ff <= (sq_cnt_ff == 5'd23);
         end
         // divide: 42 restoring steps of |v|<<18 by the root
         if (cmd.div_start) begin
            nx_ff <= {ax_abs, 18'b0}; ny_ff <= {ay_abs, 18'b0};
            px_ff <= '0; py_ff <= '0;
            dv_cnt_ff <= '0; div_done_ff <= 1'b0;
         end else if (cmd.div_step) begin
            px_ff <= wx; py_ff <= wy;
            nx_ff <= {nx_ff[40:0], 1'b0}; ny_ff <= {ny_ff[40:0], 1'b0};
            qx_ff <= {qx_ff[22:0], ~sx[26]};
            qy_ff <= {qy_ff[22:0], ~sy[26]};
            dv_cnt_ff   <= dv_cnt_ff + 6'd1;
            if (dv_cnt_ff == 6'd41) begin
               div_done_ff <= 1'b1;
               vel_x_ff <= vel_x_ff[23] ? -signed'({qx_ff[22:0], ~sx[26]})
                                        : signed'({qx_ff[22:0], ~sx[26]});
               vel_y_ff <= vel_y_ff[23] ? -signed'({qy_ff[22:0], ~sy[26]})
                                        : signed'({qy_ff[22:0], ~sy[26]});
            end
         end
         // heading from the final velocity
         if (cmd.commit) begin
            if (ay_abs > ax_abs) head_ff <= vel_y_ff[23] ? HeadNorth : HeadSouth;
            else if (ax_abs != '0) head_ff <= vel_x_ff[23] ? HeadWest : HeadEast;
         end
      end
   end

   assign rsp_data.new_pos_x   = pos_x_ff;
   assign rsp_data.new_pos_y   = pos_y_ff;
   assign rsp_data.new_vel_x   = vel_x_ff;
   assign rsp_data.new_vel_y   = vel_y_ff;
   assign rsp_data.heading_out = head_ff;

endmodule

>>> rtl/damped_motion_integrator_top.sv
// Damping off skips ST_DAMP1 and ST_DAMP2; speed limiting adds the square root
// and divider states.
// Flow: one transaction at a time; a new request is taken only once the
// result has been delivered. The square root and divider make the limited path longest.
// Reset: synchronous; velocity, position, heading and registers clear to 0.
// ----------------------------------------------------------------------------
// damped_motion_integrator_top
// Damped 2D Euler integrator for one body, fixed point.
// ----------------------------------------------------------------------------
module damped_motion_integrator_top import dmi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0] damp_rate_ff;
   logic        damp_off_ff;
   cmd_type     cmd;
   sts_type     sts;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         damp_rate_ff <= '0; damp_off_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CsrDampRate: damp_rate_ff <= csr_wdata;
            CsrDampOff:  damp_off_ff  <= csr_wdata[0];
            default:     ;
         endcase
      end
   end

   dmi_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .damp_off(damp_off_ff), .sts, .cmd
   );

   dmi_datapath u_dp (
      .clock, .reset, .req_data, .damp_rate(damp_rate_ff), .cmd, .sts, .rsp_data
   );

   // results hold under stall, and no transaction is taken while one is in flight
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");
   a_load_once: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> req_stall)
      else $error("second load without result");

endmodule

>>> test/damped_motion_integrator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_motion_integrator_top_test
// Drives acceleration/time-step transactions into the integrator under
// random idling and stalls, predicts each velocity/position/heading update
// with a fixed-point motion model and compares every result field.
// ----------------------------------------------------------------------------
module damped_motion_integrator_top_test;
   import dmi_pkg::*;

   localparam longint SNAP_Q     = 6554;
   localparam longint SPEED_SQ_Q = longint'(16) <<< 32;
   localparam longint SPEED_Q    = longint'(4) <<< 16;
   localparam int     IDLE_LIMIT = 3000;
   localparam int     RAND_ITEMS = 140;

   typedef enum logic [1:0] {ROW_PLAIN, ROW_FIXED, ROW_STEER} row_kind_type;

   // steer rows carry a target velocity in the acceleration fields
   typedef struct {
      row_kind_type kind;
      req_type      req;
      rsp_type      rsp;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write = 1'b0;
   logic        csr_index = CsrDampRate;
   logic [15:0] csr_wdata = '0;

   // motion state and register copies of the predictor
   longint      body_vx, body_vy, body_px, body_py;
   logic [1:0]  body_heading;
   longint      damp_rate;
   bit          damp_off;

   rsp_type     pending_q[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          send_quiet = 1'b0;
   bit          recv_quiet = 1'b0;

   dir_row_type dir_rows[19] = '{
      '{ROW_FIXED, '{24'sd0, 24'sd0, 16'd0}, '{32'sd0, 32'sd0, 24'sd0, 24'sd0, HeadNorth}},
      '{ROW_FIXED, '{24'sd65536, 24'sd0, 16'd4096},
         '{32'sd65536, 32'sd0, 24'sd65536, 24'sd0, HeadEast}},
      '{ROW_PLAIN, '{24'sd0, 24'sd0, 16'd4096}, '0},
      '{ROW_PLAIN, '{24'sd0, -24'sd196608, 16'd4096}, '0},
      '{ROW_PLAIN, '{VelMax, VelMax, 16'hFFFF}, '0},
      '{ROW_PLAIN, '{VelMin, VelMin, 16'hFFFF}, '0},
      '{ROW_PLAIN, '{24'sd0, 24'sd0, 16'd0}, '0},
      '{ROW_STEER, '{24'sd6553, -24'sd6553, 16'd4096}, '0},
      '{ROW_PLAIN, '{24'sd0, 24'sd0, 16'd4096}, '0},
      '{ROW_STEER, '{24'sd6554, -24'sd6554, 16'd4096}, '0},
      '{ROW_PLAIN, '{24'sd0, 24'sd0, 16'd4096}, '0},
      '{ROW_STEER, '{-24'sd6554, 24'sd6554, 16'd4096}, '0},
      '{ROW_STEER, '{24'sd100, -24'sd200, 16'd4096}, '0},
      '{ROW_STEER, '{24'sd100, 24'sd200, 16'd4096}, '0},
      '{ROW_STEER, '{24'sd0, 24'sd0, 16'd4096}, '0},
      '{ROW_PLAIN, '{24'sd1, -24'sd1, 16'hFFFF}, '0},
      '{ROW_PLAIN, '{-24'sd1, 24'sd1, 16'd1}, '0},
      '{ROW_PLAIN, '{VelMax, VelMin, 16'd1}, '0},
      '{ROW_PLAIN, '{24'sh555555, -24'sh2AAAAA, 16'hAAAA}, '0}
   };

   damped_motion_integrator_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---- fixed-point helpers -------------------------------------------------

   function automatic longint round_half_up(longint p, int k);
      return (p + (longint'(1) <<< (k - 1))) >>> k;
   endfunction

   function automatic longint clamp_width(longint x, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return (x > hi) ? hi : ((x < lo) ? lo : x);
   endfunction

   function automatic longint unsigned speed_root(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint limit_component(longint v, longint mag);
      longint a, q;
      a = (v < 0) ? -v : v;
      q = (a * SPEED_Q) / mag;
      return (v < 0) ? -q : q;
   endfunction

   // advance the body by one tick and return the update it reports
   function automatic rsp_type integrate_tick(req_type r);
      longint  ax, ay, dt, vx, vy, sq, mag, avx, avy;
      rsp_type res;
      ax = longint'(r.accel_x);
      ay = longint'(r.accel_y);
      dt = longint'(r.time_step);
      vx = body_vx;
      vy = body_vy;
      if (ax != 0 || ay != 0) begin
         vx = clamp_width(vx + round_half_up(ax * dt, 12), 24);
         vy = clamp_width(vy + round_half_up(ay * dt, 12), 24);
      end else begin
         if (vx > -SNAP_Q && vx < SNAP_Q) vx = 0;
         if (vy > -SNAP_Q && vy < SNAP_Q) vy = 0;
      end
      if (!damp_off) begin
         vx = clamp_width(vx - round_half_up(damp_rate * vx * dt, 24), 24);
         vy = clamp_width(vy - round_half_up(damp_rate * vy * dt, 24), 24);
      end
      sq = vx * vx + vy * vy;
      if (sq > SPEED_SQ_Q) begin
         mag = longint'(speed_root(longint'(sq)));
         vx = limit_component(vx, mag);
         vy = limit_component(vy, mag);
      end
      body_px = clamp_width(body_px + round_half_up(vx * dt, 12), 32);
      body_py = clamp_width(body_py + round_half_up(vy * dt, 12), 32);
      body_vx = vx;
      body_vy = vy;
      avx = (vx < 0) ? -vx : vx;
      avy = (vy < 0) ? -vy : vy;
      if (avy > avx)
         body_heading = (vy < 0) ? HeadNorth : HeadSouth;
      else if (avx != 0)
         body_heading = (vx < 0) ? HeadWest : HeadEast;
      res.new_pos_x   = 32'(body_px);
      res.new_pos_y   = 32'(body_py);
      res.new_vel_x   = 24'(body_vx);
      res.new_vel_y   = 24'(body_vy);
      res.heading_out = body_heading;
      return res;
   endfunction

   // ---- stimulus --------------------------------------------------------------

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [VelW-1:0] pick_accel();
      case ($urandom_range(0, 9))
         0: return VelW'($urandom);
         1: return VelMax;
         2: return VelMin;
         3: return '0;
         default: return VelW'($signed($urandom_range(0, 262144)) - 131072);
      endcase
   endfunction

   function automatic req_type pick_tick();
      req_type r;
      r.accel_x = pick_accel();
      r.accel_y = pick_accel();
      if ($urandom_range(0, 9) == 0) begin
         r.accel_x = '0;
         r.accel_y = '0;
      end
      case ($urandom_range(0, 7))
         0: r.time_step = DtW'($urandom);
         1: r.time_step = '0;
         2: r.time_step = 16'hFFFF;
         default: r.time_step = DtW'($urandom_range(0, 8191));
      endcase
      return r;
   endfunction

   // hand one transaction to the block; the result is predicted as it goes out
   task automatic send_tick(input req_type r, input bit fixed, input rsp_type fixed_rsp);
      int      g;
      rsp_type p;
      g = send_quiet ? 0 : pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      p = integrate_tick(r);
      pending_q.push_back(fixed ? fixed_rsp : p);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] value);
      drain();
      repeat (100) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CsrDampRate) damp_rate = longint'(value);
      else damp_off = value[0];
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      req_type r;
      logic [15:0] rates[6];
      bit          offs[6];
      body_vx = 0; body_vy = 0; body_px = 0; body_py = 0;
      body_heading = HeadNorth;
      damp_rate = 0;
      damp_off = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, with the reset register values
      foreach (dir_rows[i]) begin
         r = dir_rows[i].req;
         if (dir_rows[i].kind == ROW_STEER) begin
            r.accel_x = VelW'(longint'(r.accel_x) - body_vx);
            r.accel_y = VelW'(longint'(r.accel_y) - body_vy);
         end
         send_tick(r, dir_rows[i].kind == ROW_FIXED, dir_rows[i].rsp);
      end

      // random phases over several damping settings, extremes included
      rates = '{16'hFFFF, 16'd0, 16'd4096, 16'hFFFF, 16'd0, 16'd0};
      offs  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
      rates[4] = DtW'($urandom_range(1, 2000));
      rates[5] = DtW'($urandom);
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(CsrDampRate, rates[ph]);
         write_reg(CsrDampOff, {15'd0, offs[ph]});
         for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 35 == 0) begin
               send_quiet = ($urandom_range(0, 3) == 0);
               recv_quiet = ($urandom_range(0, 3) == 0);
            end
            // hold off until the block has delivered everything
            if (n == RAND_ITEMS / 2) drain();
            send_tick(pick_tick(), 1'b0, '0);
         end
      end

      drain();
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---- result side -----------------------------------------------------------

   // stall the result channel in bursts, mostly short
   always @(posedge clock) begin : rsp_stall_gen
      int stall_left;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else if (!recv_quiet && $urandom_range(0, 9) < 3) begin
         rsp_stall <= 1'b1;
         stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each delivered transaction with the oldest prediction
   always @(posedge clock) begin : rsp_check
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_q.size() == 0) begin
            $error("unexpected result transaction");
            error_count++;
         end else begin
            e = pending_q.pop_front();
            if (rsp_data.new_pos_x !== e.new_pos_x) begin
               $error("new_pos_x: expected %0d, got %0d", e.new_pos_x, rsp_data.new_pos_x);
               error_count++;
            end
            if (rsp_data.new_pos_y !== e.new_pos_y) begin
               $error("new_pos_y: expected %0d, got %0d", e.new_pos_y, rsp_data.new_pos_y);
               error_count++;
            end
            if (rsp_data.new_vel_x !== e.new_vel_x) begin
               $error("new_vel_x: expected %0d, got %0d", e.new_vel_x, rsp_data.new_vel_x);
               error_count++;
            end
            if (rsp_data.new_vel_y !== e.new_vel_y) begin
               $error("new_vel_y: expected %0d, got %0d", e.new_vel_y, rsp_data.new_vel_y);
               error_count++;
            end
            if (rsp_data.heading_out !== e.heading_out) begin
               $error("heading_out: expected %0d, got %0d", e.heading_out,
                      rsp_data.heading_out);
               error_count++;
            end
         end
      end
   end

   // end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
